@@ rtl/rpn_pkg.sv @@
package rpn_pkg;

    typedef enum logic [3:0] {
        OP_PUSH     = 4'd0,
        OP_ADD      = 4'd1,
        OP_SUB      = 4'd2,
        OP_MUL      = 4'd3,
        OP_DIV      = 4'd4,
        OP_MOD      = 4'd5,
        OP_PRINT    = 4'd6,
        OP_DUP      = 4'd7,
        OP_SWAP     = 4'd8,
        OP_CLEAR    = 4'd9,
        OP_POPPRINT = 4'd10
    } op_t;

    // shift command applied to every stack cell in the same cycle
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_PUSH = 2'd1,
        SH_POP  = 2'd2,
        SH_LOAD = 2'd3
    } shift_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_MUL   = 3'd1,
        ST_DIV   = 3'd2,
        ST_FIN   = 3'd3,
        ST_OUT   = 3'd4
    } state_t;

    typedef struct packed {
        shift_t      cmd;
        logic [31:0] load0;
        logic [31:0] load1;
    } stack_ctl_t;

endpackage

@@ rtl/rpn_cell.sv @@
// One stack slot: holds a value, shifts toward the bottom on push and
// toward the top on pop. Load writes the two top slots directly.
module rpn_cell (
    input  logic                aclk,
    input  rpn_pkg::stack_ctl_t ctl,
    input  logic [31:0]         above_val,
    input  logic [31:0]         below_val,
    input  logic [31:0]         load_val,
    input  logic                load_en,
    output logic [31:0]         val
);
    logic [31:0] val_reg;

    always_ff @(posedge aclk) begin
        case (ctl.cmd)
            rpn_pkg::SH_PUSH: val_reg <= above_val;
            rpn_pkg::SH_POP:  val_reg <= below_val;
            rpn_pkg::SH_LOAD: if (load_en) begin
                val_reg <= load_val;
            end
            default: val_reg <= val_reg;
        endcase
    end

    assign val = val_reg;
endmodule

@@ rtl/rpn_stack_calculator_core.sv @@
// RPN stack calculator over signed Q(31-F).F values. The stack is a row of
// STACK_DEPTH identical cells: cell 0 is the top, every push shifts all
// cells one step down and every pop one step up, so only cells 0 and 1 are
// ever read. The top cell takes load0 on every shift, so a binary result
// lands on top in the same cycle as the pop. One beat in gives one beat out.
// Simple commands go straight to the output state; mul goes through a
// registered 64-bit product, then floor shift and saturation; div and mod
// run a restoring divider that makes one quotient bit per cycle over 32+F
// steps (mod runs it on the integer parts). Input is not accepted again
// until the result beat has been taken, so the next input beat can come in
// the cycle after it. Operands are read at accept; the stack is rewritten
// in ST_OUT, from the result registered in ST_FIN for mul, div and mod and
// from the sum or difference formed there for add and sub. Modulo by zero
// with two entries pops the first of them in ST_FIN, before ST_OUT.
module rpn_stack_calculator_core #(
    parameter int STACK_DEPTH   = 128,
    parameter int FRACTION_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_operation,
    input  logic signed [31:0] s_number,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_shown_value,
    output logic               m_shown,
    output logic               m_stack_empty_error,
    output logic               m_stack_full_error,
    output logic               m_zero_divisor_error,
    output logic [7:0]         m_stack_level
);
    localparam int PW  = $clog2(STACK_DEPTH + 1);
    localparam int DW  = 32 + FRACTION_BITS;     // dividend bits
    localparam int CW  = $clog2(DW + 1);
    localparam logic [PW-1:0] DEPTH_P = PW'(STACK_DEPTH);

    rpn_pkg::state_t     state_reg, state_next;
    rpn_pkg::stack_ctl_t ctl;
    logic [PW-1:0]       sp_reg, sp_next;
    logic [3:0]          op_reg;
    logic signed [31:0]  a_reg, b_reg, num_reg;
    logic                emp_reg, emp_next;
    logic                full_reg, full_next;
    logic                zd_reg, zd_next;
    logic signed [31:0]  res_reg, res_next;
    logic signed [63:0]  prod_reg;
    logic [DW-1:0]       dq_reg;     // dividend shifting into quotient
    logic [31:0]         rem_reg;
    logic [31:0]         dsr_reg;
    logic                neg_reg, aneg_reg;
    logic [CW-1:0]       cnt_reg, cnt_needed;
    logic                start_div;
    logic signed [31:0]  top0, top1;
    logic [31:0]         cell_val [STACK_DEPTH];
    logic [31:0]         out_val_reg;
    logic                out_shown_reg, out_emp_reg, out_full_reg, out_zd_reg;
    logic [7:0]          out_lvl_reg;

    assign top0 = cell_val[0];
    assign top1 = cell_val[1];

    // top cell always shifts in load0; a plain pop drives load0 with cell 1
    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            rpn_cell u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .above_val (gi == 0 ? ctl.load0 : cell_val[gi == 0 ? 0 : gi-1]),
                .below_val (gi == 0 ? ctl.load0
                            : gi == STACK_DEPTH-1 ? 32'd0
                            : cell_val[gi == STACK_DEPTH-1 ? gi : gi+1]),
                .load_val  (gi == 0 ? ctl.load0 : ctl.load1),
                .load_en   (gi < 2),
                .val       (cell_val[gi])
            );
        end
    endgenerate

    // operand fetch with empty handling
    logic        have1, have2;
    logic signed [31:0] fb, fa;
    assign have1 = sp_reg >= PW'(1);
    assign have2 = sp_reg >= PW'(2);
    assign fb = have1 ? top0 : 32'sd0;
    assign fa = have2 ? top1 : 32'sd0;

    function automatic logic signed [31:0] sat(input logic signed [65:0] v);
        if (v > 66'sd2147483647)       return 32'sh7fffffff;
        else if (v < -66'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction

    // integer parts for mod (truncate toward zero)
    function automatic logic [31:0] int_mag(input logic signed [31:0] v);
        logic [31:0] m;
        m = v[31] ? 32'(-v) : v;
        return m >> FRACTION_BITS;
    endfunction

    logic [32:0] trial;
    assign trial = {rem_reg, dq_reg[DW-1]} - {1'b0, dsr_reg};

    assign s_ready = (state_reg == rpn_pkg::ST_IDLE) && !m_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rpn_pkg::ST_IDLE;
            sp_reg    <= '0;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (state_reg == rpn_pkg::ST_OUT) m_valid <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        emp_reg  <= emp_next;
        full_reg <= full_next;
        zd_reg   <= zd_next;
        res_reg  <= res_next;
        if (s_valid && s_ready) begin
            op_reg  <= s_operation;
            num_reg <= s_number;
            a_reg   <= fa;
            b_reg   <= fb;
        end
        if (state_reg == rpn_pkg::ST_MUL) prod_reg <= a_reg * b_reg;
        if (start_div) begin
            rem_reg <= '0;
            cnt_reg <= '0;
            dsr_reg <= (op_reg == rpn_pkg::OP_MOD) ? int_mag(b_reg)
                       : (b_reg[31] ? 32'(-b_reg) : b_reg);
            if (op_reg == rpn_pkg::OP_MOD)
                dq_reg <= DW'(int_mag(a_reg));
            else
                dq_reg <= DW'(a_reg[31] ? 32'(-a_reg) : a_reg) << FRACTION_BITS;
            neg_reg  <= a_reg[31] ^ b_reg[31];
            aneg_reg <= a_reg[31];
        end else if (state_reg == rpn_pkg::ST_DIV) begin
            cnt_reg <= cnt_reg + CW'(1);
            if (!trial[32]) begin
                rem_reg <= trial[31:0];
                dq_reg  <= {dq_reg[DW-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[30:0], dq_reg[DW-1]};
                dq_reg  <= {dq_reg[DW-2:0], 1'b0};
            end
        end
        if (state_reg == rpn_pkg::ST_OUT) begin
            out_val_reg   <= (op_reg == rpn_pkg::OP_PRINT || op_reg == rpn_pkg::OP_POPPRINT)
                             ? b_reg : 32'd0;
            out_shown_reg <= op_reg == rpn_pkg::OP_PRINT || op_reg == rpn_pkg::OP_POPPRINT;
            out_emp_reg   <= emp_reg;
            out_full_reg  <= full_next;
            out_zd_reg    <= zd_next;
            out_lvl_reg   <= 8'(sp_next);
        end
    end

    assign cnt_needed = CW'(DW);

    // control: next state, stack pointer, shift commands, result and flags
    always_comb begin
        logic signed [63:0] fl;
        logic [DW-1:0]      q;
        logic signed [65:0] qs;
        logic [31:0]        r;
        state_next = state_reg;
        sp_next    = sp_reg;
        emp_next   = emp_reg;
        full_next  = full_reg;
        zd_next    = zd_reg;
        res_next   = res_reg;
        start_div  = 1'b0;
        ctl.cmd    = rpn_pkg::SH_HOLD;
        ctl.load0  = res_reg;
        ctl.load1  = a_reg;
        fl = prod_reg >>> FRACTION_BITS;
        q  = dq_reg;
        qs = neg_reg ? -$signed(66'(q)) : $signed(66'(q));
        r  = rem_reg;
        case (state_reg)
            rpn_pkg::ST_IDLE: if (s_valid && s_ready) begin
                emp_next  = 1'b0;
                full_next = 1'b0;
                zd_next   = 1'b0;
                case (rpn_pkg::op_t'(s_operation))
                    rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL,
                    rpn_pkg::OP_MOD, rpn_pkg::OP_SWAP: emp_next = !have2;
                    rpn_pkg::OP_DIV: emp_next = !have1 || (fb != 0 && !have2);
                    rpn_pkg::OP_PRINT, rpn_pkg::OP_DUP,
                    rpn_pkg::OP_POPPRINT: emp_next = !have1;
                    default: emp_next = 1'b0;
                endcase
                case (rpn_pkg::op_t'(s_operation))
                    rpn_pkg::OP_MUL: state_next = rpn_pkg::ST_MUL;
                    rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: state_next = rpn_pkg::ST_FIN;
                    default: state_next = rpn_pkg::ST_OUT;
                endcase
                if (s_operation == rpn_pkg::OP_DIV || s_operation == rpn_pkg::OP_MOD)
                    state_next = rpn_pkg::ST_MUL;
            end
            rpn_pkg::ST_MUL: begin
                if (op_reg == rpn_pkg::OP_DIV || op_reg == rpn_pkg::OP_MOD) begin
                    start_div  = 1'b1;
                    state_next = rpn_pkg::ST_DIV;
                end else begin
                    state_next = rpn_pkg::ST_FIN;
                end
            end
            rpn_pkg::ST_DIV: begin
                if (cnt_reg == cnt_needed - CW'(1)) state_next = rpn_pkg::ST_FIN;
            end
            rpn_pkg::ST_FIN: begin
                case (rpn_pkg::op_t'(op_reg))
                    rpn_pkg::OP_MUL: res_next = sat({{2{fl[63]}}, fl});
                    rpn_pkg::OP_DIV: res_next = sat(qs);
                    default: res_next = 32'((aneg_reg ? 32'(-r) : r) << FRACTION_BITS);
                endcase
                // mod by zero drops two entries: first of the two pops here
                if (op_reg == rpn_pkg::OP_MOD && int_mag(b_reg) == 32'd0 && have2) begin
                    ctl.cmd   = rpn_pkg::SH_POP;
                    ctl.load0 = top1;
                end
                state_next = rpn_pkg::ST_OUT;
            end
            rpn_pkg::ST_OUT: begin
                state_next = rpn_pkg::ST_IDLE;
                case (rpn_pkg::op_t'(op_reg))
                    rpn_pkg::OP_PUSH: begin
                        ctl.load0 = num_reg;
                        if (sp_reg < DEPTH_P) begin
                            ctl.cmd = rpn_pkg::SH_PUSH;
                            sp_next = sp_reg + PW'(1);
                        end else full_next = 1'b1;
                    end
                    rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL: begin
                        if (op_reg == rpn_pkg::OP_ADD)
                            ctl.load0 = sat(66'(a_reg) + 66'(b_reg));
                        else if (op_reg == rpn_pkg::OP_SUB)
                            ctl.load0 = sat(66'(a_reg) - 66'(b_reg));
                        if (have2) begin
                            ctl.cmd = rpn_pkg::SH_POP;
                            sp_next = sp_reg - PW'(1);
                            ctl.load0 = ctl.load0;
                        end else begin
                            ctl.cmd = rpn_pkg::SH_PUSH;
                            if (have1) ctl.cmd = rpn_pkg::SH_LOAD;
                            sp_next = PW'(1);
                        end
                    end
                    rpn_pkg::OP_DIV: begin
                        if (b_reg == 0) begin
                            zd_next = 1'b1;
                            if (have1) begin
                                ctl.cmd   = rpn_pkg::SH_POP;
                                ctl.load0 = top1;
                                sp_next   = sp_reg - PW'(1);
                            end
                        end else if (have2) begin
                            ctl.cmd = rpn_pkg::SH_POP;
                            sp_next = sp_reg - PW'(1);
                        end else begin
                            ctl.cmd = rpn_pkg::SH_LOAD;
                            sp_next = PW'(1);
                        end
                    end
                    rpn_pkg::OP_MOD: begin
                        if (int_mag(b_reg) == 32'd0) begin
                            zd_next = 1'b1;
                            if (have2) begin
                                ctl.cmd   = rpn_pkg::SH_POP;
                                ctl.load0 = top1;
                                sp_next   = sp_reg - PW'(2);
                            end else sp_next = '0;
                        end else if (have2) begin
                            ctl.cmd = rpn_pkg::SH_POP;
                            sp_next = sp_reg - PW'(1);
                        end else begin
                            ctl.cmd = rpn_pkg::SH_LOAD;
                            sp_next = PW'(1);
                        end
                    end
                    rpn_pkg::OP_DUP: begin
                        ctl.load0 = b_reg;
                        if (sp_reg < DEPTH_P) begin
                            ctl.cmd = rpn_pkg::SH_PUSH;
                            sp_next = sp_reg + PW'(1);
                        end else full_next = 1'b1;
                    end
                    rpn_pkg::OP_SWAP: begin
                        ctl.cmd   = rpn_pkg::SH_LOAD;
                        ctl.load0 = a_reg;
                        ctl.load1 = b_reg;
                        sp_next   = have2 ? sp_reg : PW'(2);
                    end
                    rpn_pkg::OP_CLEAR: sp_next = '0;
                    rpn_pkg::OP_POPPRINT: if (have1) begin
                        ctl.cmd   = rpn_pkg::SH_POP;
                        ctl.load0 = top1;
                        sp_next   = sp_reg - PW'(1);
                    end
                    default: ;
                endcase
            end
            default: state_next = rpn_pkg::ST_IDLE;
        endcase
    end

    assign m_shown_value        = out_val_reg;
    assign m_shown              = out_shown_reg;
    assign m_stack_empty_error  = out_emp_reg;
    assign m_stack_full_error   = out_full_reg;
    assign m_zero_divisor_error = out_zd_reg;
    assign m_stack_level        = out_lvl_reg;

    // assertions
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= DEPTH_P) else $error("stack pointer beyond depth");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    a_out_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rpn_pkg::ST_OUT) |=> m_valid) else $error("result beat missing");
endmodule
